// ----- rtl/core/i2cee_pkg.sv -----
// shared types and constants for the i2c eeprom slave emulator
package i2cee_pkg;

  localparam logic [2:0] KIND_WRITE_ADDR = 3'd0;
  localparam logic [2:0] KIND_BYTE_ACK   = 3'd1;
  localparam logic [2:0] KIND_BYTE_NACK  = 3'd2;
  localparam logic [2:0] KIND_STOP       = 3'd3;
  localparam logic [2:0] KIND_READ       = 3'd4;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_WADDR,
    OP_BYTE_ACK,
    OP_BYTE_NACK,
    OP_STOP,
    OP_READ,
    OP_OTHER,
    OP_CM_RD,
    OP_CM_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fill_zero;
    logic cm_last;
  } dp_status_t;

endpackage

// ----- rtl/core/i2c_eeprom_slave_emulator.sv -----
// top level of the i2c eeprom slave emulator
// usage:
//   input channel (in_valid/in_stall) carries one matched bus event per item:
//   in_kind selects write addressed, byte acked, byte nacked, stop, read
//   request or other; in_data_byte is the byte received from the master.
//   result channel (out_valid/out_stall) returns exactly one item per input
//   item: out_ack_next tells whether to ack the next received byte, and
//   out_tx_byte holds the byte to send on a read request, zero otherwise.
// sequencing:
//   an accepted item goes to a finish state that loads the output register
//   once it is free; a stop with n buffered bytes first does one page buffer
//   read and one write of the single-port array per byte. one item is in
//   flight at a time.
// reset:
//   synchronous rst_n clears the address and fill state, then a clearing pass
//   writes every array entry to 0xff, with in_stall high.
// stalls:
//   the result sits in an output register until taken; while out_stall is
//   high the next item can be accepted and worked, and it waits in its final
//   state until the output register is free.
module i2c_eeprom_slave_emulator import i2cee_pkg::*; #(
  parameter int PAGE_BYTES = 8,
  parameter int MEM_DEPTH  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ack_next,
  output logic [7:0] out_tx_byte
);

  dp_cmd_t    cmd;
  dp_status_t status;

  i2cee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  i2cee_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .MEM_DEPTH  (MEM_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_data_byte (in_data_byte),
    .out_ack_next (out_ack_next),
    .out_tx_byte  (out_tx_byte)
  );

endmodule

// ----- rtl/core/i2cee_dp.sv -----
// datapath: eeprom array, page buffer, address and fill registers, result registers
module i2cee_dp import i2cee_pkg::*; #(
  parameter int PAGE_BYTES = 8,
  parameter int MEM_DEPTH  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic [7:0] in_data_byte,
  output logic       out_ack_next,
  output logic [7:0] out_tx_byte
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int PW = $clog2(PAGE_BYTES);
  localparam int FW = $clog2(PAGE_BYTES + 1);
  localparam int VW = AW + 4;

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    page [PAGE_BYTES];

  logic [AW-1:0] word_addr_r, word_addr_nxt;
  logic          addr_taken_r, addr_taken_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] clr_ptr_r, clr_ptr_nxt;
  logic [AW-1:0] cptr_r, cptr_nxt;
  logic [PW-1:0] cidx_r, cidx_nxt;
  logic          res_ack_r, res_ack_nxt;
  logic          res_mem_r, res_mem_nxt;
  logic [7:0]    mem_q_r;
  logic [7:0]    pbuf_q_r;
  logic          out_ack_r;
  logic [7:0]    out_tx_r;

  logic          page_we;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  function automatic logic [AW-1:0] byte_to_addr(input logic [7:0] b);
    logic [VW-1:0] v;
    v = VW'(b);
    for (int k = 3; k >= 0; k--) begin
      if (v >= (VW'(MEM_DEPTH) << k)) begin
        v = v - (VW'(MEM_DEPTH) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    return (a == AW'(MEM_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign status.clr_last  = (clr_ptr_r == AW'(MEM_DEPTH - 1));
  assign status.fill_zero = (fill_r == '0);
  assign status.cm_last   = ((FW'(cidx_r) + FW'(1)) == fill_r);

  always_comb begin
    word_addr_nxt  = word_addr_r;
    addr_taken_nxt = addr_taken_r;
    fill_nxt       = fill_r;
    clr_ptr_nxt    = clr_ptr_r;
    cptr_nxt       = cptr_r;
    cidx_nxt       = cidx_r;
    res_ack_nxt    = res_ack_r;
    res_mem_nxt    = res_mem_r;
    page_we        = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cptr_r;
    mem_wdata      = pbuf_q_r;
    case (cmd.op)
      OP_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_ptr_r;
        mem_wdata   = ERASED_BYTE;
        clr_ptr_nxt = addr_inc(clr_ptr_r);
      end
      OP_WADDR: begin
        addr_taken_nxt = 1'b0;
        fill_nxt       = '0;
        res_ack_nxt    = 1'b1;
        res_mem_nxt    = 1'b0;
      end
      OP_BYTE_ACK, OP_BYTE_NACK: begin
        if (!addr_taken_r) begin
          word_addr_nxt  = byte_to_addr(in_data_byte);
          addr_taken_nxt = 1'b1;
        end else if (fill_r < FW'(PAGE_BYTES)) begin
          page_we  = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
        res_ack_nxt = (cmd.op == OP_BYTE_NACK) || (fill_nxt != FW'(PAGE_BYTES - 1));
        res_mem_nxt = 1'b0;
      end
      OP_STOP: begin
        cptr_nxt    = word_addr_r;
        cidx_nxt    = '0;
        res_ack_nxt = 1'b1;
        res_mem_nxt = 1'b0;
      end
      OP_READ: begin
        word_addr_nxt = addr_inc(word_addr_r);
        res_ack_nxt   = 1'b1;
        res_mem_nxt   = 1'b1;
      end
      OP_OTHER: begin
        res_ack_nxt = 1'b1;
        res_mem_nxt = 1'b0;
      end
      OP_CM_WR: begin
        mem_we   = 1'b1;
        cptr_nxt = addr_inc(cptr_r);
        cidx_nxt = cidx_r + 1'b1;
        if (status.cm_last) begin
          word_addr_nxt = addr_inc(cptr_r);
          fill_nxt      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_addr_r  <= '0;
      addr_taken_r <= 1'b0;
      fill_r       <= '0;
      clr_ptr_r    <= '0;
    end else begin
      word_addr_r  <= word_addr_nxt;
      addr_taken_r <= addr_taken_nxt;
      fill_r       <= fill_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cptr_r    <= cptr_nxt;
    cidx_r    <= cidx_nxt;
    res_ack_r <= res_ack_nxt;
    res_mem_r <= res_mem_nxt;
    if (cmd.load_out) begin
      out_ack_r <= res_ack_r;
      out_tx_r  <= res_mem_r ? mem_q_r : 8'h00;
    end
  end

  // single-port eeprom array
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end else if (cmd.op == OP_READ) begin
      mem_q_r <= mem[word_addr_r];
    end
  end

  // page buffer
  always_ff @(posedge clk) begin
    if (page_we) begin
      page[fill_r[PW-1:0]] <= in_data_byte;
    end
    if (cmd.op == OP_CM_RD) begin
      pbuf_q_r <= page[cidx_r];
    end
  end

  assign out_ack_next = out_ack_r;
  assign out_tx_byte  = out_tx_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(PAGE_BYTES))
    else $error("page fill count beyond page size");

  a_fill_needs_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !addr_taken_r |-> fill_r == '0)
    else $error("bytes buffered before word address taken");

  a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_CM_WR |-> fill_r != '0)
    else $error("commit write with empty page buffer");

  a_commit_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CM_WR && status.cm_last) |=> fill_r == '0)
    else $error("page buffer not emptied after commit");

endmodule

// ----- rtl/core/i2cee_ctrl.sv -----
// controller: clearing pass, item sequencing, page commit and output handshake
module i2cee_ctrl import i2cee_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CM_RD,
    ST_CM_WR,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = OP_IDLE;
    cmd.load_out  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FIN;
          case (in_kind)
            KIND_WRITE_ADDR: cmd.op = OP_WADDR;
            KIND_BYTE_ACK:   cmd.op = OP_BYTE_ACK;
            KIND_BYTE_NACK:  cmd.op = OP_BYTE_NACK;
            KIND_STOP: begin
              cmd.op = OP_STOP;
              if (!status.fill_zero) begin
                state_nxt = ST_CM_RD;
              end
            end
            KIND_READ:       cmd.op = OP_READ;
            default:         cmd.op = OP_OTHER;
          endcase
        end
      end
      ST_CM_RD: begin
        cmd.op    = OP_CM_RD;
        state_nxt = ST_CM_WR;
      end
      ST_CM_WR: begin
        cmd.op    = OP_CM_WR;
        state_nxt = status.cm_last ? ST_FIN : ST_CM_RD;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && status.clr_last) |=> state_r == ST_IDLE)
    else $error("clearing pass did not end at last entry");

  a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while held");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !cmd.load_out || state_r == ST_FIN)
    else $error("result loaded outside finish state");

endmodule

// ----- tb/i2c_eeprom_slave_emulator_test.sv -----
// self-checking testbench for the i2c eeprom slave emulator: bus events in, replies checked
module i2c_eeprom_slave_emulator_test;
  import i2cee_pkg::*;

  localparam int PAGE_SIZE = 8;
  localparam int MEM_SIZE = 256;
  localparam logic [2:0] KIND_OTHER = 3'd5;
  localparam logic [2:0] KIND_LAST = 3'd7;
  localparam int ITEMS_PER_PHASE = 530;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;

  class eeprom_scoreboard;
    typedef struct packed {
      logic       ack_next;
      logic [7:0] tx_byte;
    } reply_t;

    logic [7:0] mem [MEM_SIZE];
    logic [7:0] page [PAGE_SIZE];
    logic [7:0] word_addr;
    bit         addr_taken;
    logic [3:0] fill;
    reply_t     replies [$];
    int         errors;

    function new();
      foreach (mem[i]) mem[i] = ERASED_BYTE;
      foreach (page[i]) page[i] = 8'h00;
      word_addr = 8'h00;
      addr_taken = 1'b0;
      fill = 4'd0;
      errors = 0;
    endfunction

    function void take_byte(logic [7:0] data);
      if (!addr_taken) begin
        word_addr = data;
        addr_taken = 1'b1;
      end else if (fill < PAGE_SIZE) begin
        page[fill] = data;
        fill = fill + 4'd1;
      end
    endfunction

    function void note_item(logic [2:0] kind, logic [7:0] data);
      reply_t     r;
      logic [7:0] slot;
      r.ack_next = 1'b1;
      r.tx_byte = 8'h00;
      case (kind)
        KIND_WRITE_ADDR: begin
          addr_taken = 1'b0;
          fill = 4'd0;
        end
        KIND_BYTE_ACK: begin
          take_byte(data);
          if (fill == PAGE_SIZE - 1) r.ack_next = 1'b0;
        end
        KIND_BYTE_NACK: take_byte(data);
        KIND_STOP: begin
          for (int i = 0; i < fill; i++) begin
            slot = word_addr + i[7:0];
            mem[slot] = page[i];
          end
          word_addr = word_addr + {4'd0, fill};
          fill = 4'd0;
        end
        KIND_READ: begin
          r.tx_byte = mem[word_addr];
          word_addr = word_addr + 8'd1;
        end
        default: ;
      endcase
      replies.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic ack_next, logic [7:0] tx_byte);
      reply_t r;
      if (replies.size() == 0) begin
        report("reply with nothing expected");
      end else begin
        r = replies.pop_front();
        if (ack_next !== r.ack_next)
          report($sformatf("ack_next got %b want %b", ack_next, r.ack_next));
        if (tx_byte !== r.tx_byte)
          report($sformatf("tx_byte got %02h want %02h", tx_byte, r.tx_byte));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_kind = KIND_OTHER;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_ack_next;
  logic [7:0] out_tx_byte;

  int send_idle = 33;
  int recv_idle = 46;
  int cycles = 0;
  eeprom_scoreboard model;

  i2c_eeprom_slave_emulator u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ack_next (out_ack_next),
    .out_tx_byte  (out_tx_byte)
  );

  always #10 clk = ~clk;

  task automatic send_event(input logic [2:0] kind, input logic [7:0] data);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.note_item(kind, data);
  endtask

  task automatic random_traffic(input int count);
    int         sent;
    int         n;
    int         pick;
    logic [7:0] base;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      base = 8'($urandom_range(255));
      if ($urandom_range(3) != 0) base = 8'hE8 + {2'b00, base[5:0]};
      if (pick < 55) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(7);
        send_event(KIND_WRITE_ADDR, 8'($urandom));
        send_event(KIND_BYTE_ACK, base);
        for (int i = 0; i < n; i++)
          send_event(($urandom_range(5) == 0) ? KIND_BYTE_NACK : KIND_BYTE_ACK,
                     8'($urandom));
        send_event(KIND_STOP, 8'($urandom));
        sent += n + 3;
      end else if (pick < 85) begin
        if ($urandom_range(1) == 1) begin
          send_event(KIND_WRITE_ADDR, 8'($urandom));
          send_event(KIND_BYTE_ACK, base);
          if ($urandom_range(1) == 1) send_event(KIND_STOP, 8'($urandom));
          sent += 3;
        end
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) send_event(KIND_READ, 8'($urandom));
        sent += n;
      end else begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
          send_event(3'($urandom_range(KIND_LAST)), 8'($urandom));
        sent += n;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) model.check_result(out_ack_next, out_tx_byte);
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] page_fill [9];
    page_fill = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h3C};
    model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // data byte before any write addressed sets the address
    send_event(KIND_BYTE_ACK, 8'hFC);
    send_event(KIND_READ, 8'h00);
    // full page at the top of memory, commit wraps, extra bytes dropped
    send_event(KIND_WRITE_ADDR, 8'h00);
    send_event(KIND_BYTE_ACK, 8'hFC);
    foreach (page_fill[i]) send_event(KIND_BYTE_ACK, page_fill[i]);
    send_event(KIND_BYTE_NACK, 8'h80);
    send_event(KIND_STOP, 8'hFF);
    // stop on an empty buffer
    send_event(KIND_STOP, 8'h00);
    for (int k = KIND_OTHER; k <= KIND_LAST; k++) send_event(k[2:0], 8'hFF);
    // nacked byte as address, then reads across the wrap
    send_event(KIND_WRITE_ADDR, 8'hFF);
    send_event(KIND_BYTE_NACK, 8'hFE);
    repeat (4) send_event(KIND_READ, 8'hFF);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 33 : (phase == 1) ? 46 : 0;
      recv_idle = (phase == 0) ? 46 : (phase == 1) ? 33 : 0;
      random_traffic(ITEMS_PER_PHASE);
    end
    in_valid <= 1'b0;

    while (model.replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.replies.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/i2cee_pkg.sv
rtl/core/i2cee_dp.sv
rtl/core/i2cee_ctrl.sv
rtl/core/i2c_eeprom_slave_emulator.sv
tb/i2c_eeprom_slave_emulator_test.sv
